/* rtl/tcpaq_pkg.sv */
// ----------------------------------------------------------------------------
// tcpaq_pkg
// Shared types and codes of the two-class priority admission queue.
// ----------------------------------------------------------------------------
package tcpaq_pkg;

	localparam int FUNC_W   = 2;
	localparam int CLIENT_W = 6;
	localparam int SERVER_W = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;
	localparam int CSTATE_W = 2;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	// item kinds
	localparam logic [FUNC_W-1:0] FUNC_ARRIVE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FINISH   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_LEAVE    = 2'd3;

	// result codes
	localparam logic [STATUS_W-1:0] RES_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] RES_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] RES_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] RES_LIMIT = 2'd3;

	// requester states
	localparam logic [CSTATE_W-1:0] ST_WAITING  = 2'd0;
	localparam logic [CSTATE_W-1:0] ST_ASSIGNED = 2'd1;
	localparam logic [CSTATE_W-1:0] ST_SERVED   = 2'd2;

	localparam logic [COUNT_W-1:0] MAX_INSIDE_RESET = 8'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'hFF;

	// one entry of the requester status store
	typedef struct packed {
		logic [CSTATE_W-1:0] state;
		logic [SERVER_W-1:0] server;
	} req_entry_t;

	// queue control from the sequencer
	typedef struct packed {
		logic rd_en;
		logic push;
		logic pop;
	} queue_ctl_t;

	// queue status back to the sequencer
	typedef struct packed {
		logic full;
		logic empty;
	} queue_sts_t;

endpackage

/* rtl/two_class_priority_admission_queue.sv */
// ----------------------------------------------------------------------------
// two_class_priority_admission_queue
// Strict-priority two-class queue of requester ids with admission control.
// Timing: a result is loaded into the output register when the work stage
//   fires, once the output register is free, and then shows on m_tvalid.
// Items: one at a time; a new item is taken once the last result is loaded.
//   Queue and status memories are read on accept, written back on fire.
// Reset: arst_n clears queue pointers, admitted count and status valid bits at
//   once; max_inside returns to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
module two_class_priority_admission_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int NUM_CLIENTS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration: max_inside
	input  logic                               cfg_we,
	input  logic [tcpaq_pkg::COUNT_W-1:0]      cfg_wdata,
	// input items
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [5:0] client_id, [6] is_priority, [9:7] server_id, [15:10] zero
	input  logic [tcpaq_pkg::IN_DATA_W-1:0]    s_tdata,
	// [1:0] func
	input  logic [tcpaq_pkg::FUNC_W-1:0]       s_tuser,
	// result items
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [1:0] status, [7:2] granted_client, [8] granted_priority,
	// [16:9] inside_count, [18:17] client_state, [23:19] zero
	output logic [tcpaq_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import tcpaq_pkg::*;

	// ids are six bits wide, so no more than 64 status entries are reachable
	localparam int STORE_DEPTH = (NUM_CLIENTS < 64) ? NUM_CLIENTS : 64;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam logic [CLIENT_W:0] STORE_LIMIT = (CLIENT_W + 1)'(STORE_DEPTH);

	// item fields at the port
	logic [CLIENT_W-1:0] in_cid;
	logic                in_prio;
	logic [SERVER_W-1:0] in_sid;

	assign in_cid  = s_tdata[5:0];
	assign in_prio = s_tdata[6];
	assign in_sid  = s_tdata[9:7];

	// held item under work
	logic                busy_q;
	logic [FUNC_W-1:0]   func_q;
	logic [CLIENT_W-1:0] cid_q;
	logic                prio_q;
	logic [SERVER_W-1:0] sid_q;

	logic [COUNT_W-1:0]  max_inside_q;
	logic [COUNT_W-1:0]  admitted_q;

	logic                m_tvalid_q;

	logic                accept;
	logic                fire;

	// queue and store interfaces
	queue_ctl_t          p_ctl, n_ctl;
	queue_sts_t          p_sts, n_sts;
	logic [CLIENT_W-1:0] p_head, n_head;
	req_entry_t          rd_entry;
	logic                st_wr_en;
	logic [IDX_W-1:0]    st_wr_addr;
	req_entry_t          st_wr_entry;

	// result of the item under work
	logic [STATUS_W-1:0] res_status;
	logic [CLIENT_W-1:0] res_granted;
	logic                res_gprio;
	logic [COUNT_W-1:0]  admitted_next;
	logic [CSTATE_W-1:0] res_cstate;
	logic                cid_in_range;
	logic                grant_in_range;
	logic [CLIENT_W-1:0] head_pick;

	// Accept only with no item at work; the item's results then find the
	// output register free or wait for it in the work stage.
	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign fire     = busy_q && (!m_tvalid_q || m_tready);

	// Prefetch both queue heads and the addressed status entry on accept; work out the held item's result and updates.
	always_comb begin
		p_ctl.rd_en = accept;
		n_ctl.rd_en = accept;
		p_ctl.push  = 1'b0;
		p_ctl.pop   = 1'b0;
		n_ctl.push  = 1'b0;
		n_ctl.pop   = 1'b0;

		res_status    = RES_OK;
		res_granted   = '0;
		res_gprio     = 1'b0;
		admitted_next = admitted_q;
		res_cstate    = ST_WAITING;
		st_wr_en      = 1'b0;
		st_wr_addr    = cid_q[IDX_W-1:0];
		st_wr_entry   = rd_entry;

		head_pick = p_sts.empty ? n_head : p_head;

		cid_in_range   = ({1'b0, cid_q} < STORE_LIMIT);
		grant_in_range = ({1'b0, head_pick} < STORE_LIMIT);

		unique case (func_q)
			FUNC_ARRIVE: begin
				// push into the class queue, or flag full; state is untouched
				if (prio_q ? p_sts.full : n_sts.full) begin
					res_status = RES_FULL;
				end else begin
					p_ctl.push = fire && prio_q;
					n_ctl.push = fire && !prio_q;
				end
				res_cstate = cid_in_range ? rd_entry.state : ST_WAITING;
			end
			FUNC_DISPATCH: begin
				// empty wins over the limit; priority queue first
				if (p_sts.empty && n_sts.empty) begin
					res_status = RES_EMPTY;
				end else if (admitted_q >= max_inside_q) begin
					res_status = RES_LIMIT;
				end else begin
					res_granted = head_pick;
					res_gprio   = !p_sts.empty;
					p_ctl.pop   = fire && !p_sts.empty;
					n_ctl.pop   = fire && p_sts.empty;
					st_wr_en    = fire && grant_in_range;
					st_wr_addr  = head_pick[IDX_W-1:0];
					st_wr_entry.state  = ST_ASSIGNED;
					st_wr_entry.server = sid_q;
					if (admitted_q != COUNT_MAX) begin
						admitted_next = admitted_q + 1'b1;
					end
					res_cstate = grant_in_range ? ST_ASSIGNED : ST_WAITING;
				end
			end
			FUNC_FINISH: begin
				// mark served, keep the recorded server
				st_wr_en          = fire && cid_in_range;
				st_wr_entry.state = ST_SERVED;
				res_cstate        = cid_in_range ? ST_SERVED : ST_WAITING;
			end
			FUNC_LEAVE: begin
				// drop the count, saturating at zero
				if (admitted_q != '0) begin
					admitted_next = admitted_q - 1'b1;
				end
				res_cstate = cid_in_range ? rd_entry.state : ST_WAITING;
			end
			default: begin
			end
		endcase
	end

	tcpaq_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_prio_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (p_ctl),
		.push_data(cid_q),
		.head_data(p_head),
		.sts      (p_sts)
	);

	tcpaq_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_norm_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (n_ctl),
		.push_data(cid_q),
		.head_data(n_head),
		.sts      (n_sts)
	);

	tcpaq_status_store #(
		.DEPTH(STORE_DEPTH),
		.IDX_W(IDX_W)
	) u_status_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_cid[IDX_W-1:0]),
		.rd_entry(rd_entry),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_entry(st_wr_entry)
	);

	// Control: work flag, admitted count, limit register, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			admitted_q   <= '0;
			max_inside_q <= MAX_INSIDE_RESET;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_inside_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				admitted_q <= admitted_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted item; load the result when the work stage fires.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tuser;
			cid_q  <= in_cid;
			prio_q <= in_prio;
			sid_q  <= in_sid;
		end
		if (fire) begin
			m_tdata <= {5'd0, res_cstate, admitted_next, res_gprio, res_granted, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;

	// A finished item always leaves a result in the output register.
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("work stage fired without a result");

	// One item at work: no accept in the cycle after an accept.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("item accepted while another is at work");

	// A pop never hits an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!((p_ctl.pop && p_sts.empty) || (n_ctl.pop && n_sts.empty)))
		else $error("pop from an empty queue");

	// A push never hits a full queue.
	a_push_nonfull: assert property (@(posedge clk) disable iff (!arst_n)
		!((p_ctl.push && p_sts.full) || (n_ctl.push && n_sts.full)))
		else $error("push into a full queue");

endmodule

/* rtl/tcpaq_queue.sv */
// ----------------------------------------------------------------------------
// tcpaq_queue
// FIFO of requester ids in a synchronous memory; the head is read ahead into a register on rd_en.
// ----------------------------------------------------------------------------
module tcpaq_queue #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcpaq_pkg::queue_ctl_t         ctl,
	input  logic [tcpaq_pkg::CLIENT_W-1:0] push_data,
	output logic [tcpaq_pkg::CLIENT_W-1:0] head_data,
	output tcpaq_pkg::queue_sts_t         sts
);
	import tcpaq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [CLIENT_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    tail_sum;
	logic [PTR_W-1:0]    tail;
	logic [PTR_W-1:0]    head_next;

	// head + count stays below twice the depth: one compare and subtract wraps it
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
	                                          : PTR_W'(tail_sum);
	assign head_next = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	assign sts.full  = (count_q == CNT_W'(DEPTH));
	assign sts.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail] <= push_data;
		end
		if (ctl.rd_en) begin
			head_data <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop) begin
				head_q  <= head_next;
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/tcpaq_status_store.sv */
// ----------------------------------------------------------------------------
// tcpaq_status_store
// Per-requester state and server in a synchronous memory; valid bits make
// unwritten entries read as waiting with server zero.
// ----------------------------------------------------------------------------
module tcpaq_status_store #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output tcpaq_pkg::req_entry_t rd_entry,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  tcpaq_pkg::req_entry_t wr_entry
);
	import tcpaq_pkg::*;

	req_entry_t       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	req_entry_t       rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_valid_q ? rd_data_q : '0;

endmodule

/* test/two_class_priority_admission_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_admission_queue_tb
// Self-checking bench for the two-class priority admission queue. It runs a
// directed opening and then random phases under several max_inside limits.
// Traffic on both streams is bursty. A scoreboard class predicts every result
// item and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module two_class_priority_admission_queue_tb;
	import tcpaq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_CLIENTS = 64;
	localparam int IDLE_LIMIT  = 400;   // cycles without any handshake
	localparam int PHASE_ITEMS = 80;
	localparam int GRANT_DEPTH = 16;    // recent grants kept for finish/leave ids

	// expected content of one result item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CLIENT_W-1:0] granted;
		logic                gprio;
		logic [COUNT_W-1:0]  count;
		logic [CSTATE_W-1:0] cstate;
	} outcome_t;

	// Predict each accepted item and hold the outcomes until the block answers.
	class admission_scoreboard;
		logic [CLIENT_W-1:0] prio_ids[$];
		logic [CLIENT_W-1:0] normal_ids[$];
		logic [CSTATE_W-1:0] client_st[NUM_CLIENTS];
		logic [SERVER_W-1:0] client_srv[NUM_CLIENTS];
		logic [COUNT_W-1:0]  admitted;
		logic [COUNT_W-1:0]  max_inside;
		outcome_t            awaited[$];
		logic [CLIENT_W-1:0] recent_grants[$];
		int                  errors;
		int                  results_seen;

		function new();
			admitted     = '0;
			max_inside   = MAX_INSIDE_RESET;
			errors       = 0;
			results_seen = 0;
			foreach (client_st[i]) begin
				client_st[i]  = ST_WAITING;
				client_srv[i] = '0;
			end
		endfunction

		function logic [CSTATE_W-1:0] state_of(logic [CLIENT_W-1:0] id);
			return (int'(id) < NUM_CLIENTS) ? client_st[id] : ST_WAITING;
		endfunction

		function void note_item(logic [FUNC_W-1:0] f, logic [CLIENT_W-1:0] cid,
				logic pr, logic [SERVER_W-1:0] sid);
			outcome_t o;
			o = '0;
			o.status = RES_OK;
			case (f)
			FUNC_ARRIVE: begin
				if (pr) begin
					if (prio_ids.size() >= QUEUE_DEPTH) o.status = RES_FULL;
					else prio_ids.push_back(cid);
				end else begin
					if (normal_ids.size() >= QUEUE_DEPTH) o.status = RES_FULL;
					else normal_ids.push_back(cid);
				end
				o.cstate = state_of(cid);
			end
			FUNC_DISPATCH: begin
				// empty wins over the limit
				if (prio_ids.size() == 0 && normal_ids.size() == 0) begin
					o.status = RES_EMPTY;
				end else if (admitted >= max_inside) begin
					o.status = RES_LIMIT;
				end else begin
					if (prio_ids.size() > 0) begin
						o.granted = prio_ids.pop_front();
						o.gprio   = 1'b1;
					end else begin
						o.granted = normal_ids.pop_front();
					end
					if (int'(o.granted) < NUM_CLIENTS) begin
						client_st[o.granted]  = ST_ASSIGNED;
						client_srv[o.granted] = sid;
					end
					if (admitted != COUNT_MAX) admitted++;
					o.cstate = state_of(o.granted);
					recent_grants.push_back(o.granted);
					if (recent_grants.size() > GRANT_DEPTH) void'(recent_grants.pop_front());
				end
			end
			FUNC_FINISH: begin
				// served even if never assigned
				if (int'(cid) < NUM_CLIENTS) client_st[cid] = ST_SERVED;
				o.cstate = state_of(cid);
			end
			default: begin
				if (admitted != '0) admitted--;
				o.cstate = state_of(cid);
			end
			endcase
			o.count = admitted;
			awaited.push_back(o);
		endfunction

		task report_mismatch(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [OUT_DATA_W-1:0] d);
			outcome_t w;
			results_seen++;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no item pending: %h",
					results_seen, d));
			end else begin
				w = awaited.pop_front();
				if (d[1:0] != w.status)
					report_mismatch($sformatf("result %0d status: got %0d, want %0d",
						results_seen, d[1:0], w.status));
				if (d[7:2] != w.granted)
					report_mismatch($sformatf("result %0d granted_client: got %0d, want %0d",
						results_seen, d[7:2], w.granted));
				if (d[8] != w.gprio)
					report_mismatch($sformatf("result %0d granted_priority: got %0d, want %0d",
						results_seen, d[8], w.gprio));
				if (d[16:9] != w.count)
					report_mismatch($sformatf("result %0d inside_count: got %0d, want %0d",
						results_seen, d[16:9], w.count));
				if (d[18:17] != w.cstate)
					report_mismatch($sformatf("result %0d client_state: got %0d, want %0d",
						results_seen, d[18:17], w.cstate));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [COUNT_W-1:0]    cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	// [5:0] client_id, [6] is_priority, [9:7] server_id, [15:10] zero
	logic [IN_DATA_W-1:0]  s_tdata;
	// [1:0] func
	logic [FUNC_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [1:0] status, [7:2] granted_client, [8] granted_priority,
	// [16:9] inside_count, [18:17] client_state, [23:19] zero
	logic [OUT_DATA_W-1:0] m_tdata;

	admission_scoreboard sb;
	int                  burst_left;

	two_class_priority_admission_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.NUM_CLIENTS(NUM_CLIENTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one item at a falling edge and hold it until the block takes it.
	// Open a gap of random length whenever the current burst runs out.
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CLIENT_W-1:0] cid,
			input logic pr, input logic [SERVER_W-1:0] sid);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			// now and then a long burst with no idling at all
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {6'd0, sid, pr, cid};
		do @(posedge clk); while (!s_tready);
		sb.note_item(f, cid, pr, sid);
	endtask

	// Drain everything in flight, then write the limit while the block is idle.
	task automatic write_max_inside(input logic [COUNT_W-1:0] value);
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk) cfg_we <= 1'b0;
		sb.max_inside = value;
	endtask

	// Receiver: ready runs and stalls of random length, with the odd long
	// stall and the odd long stretch of no stalling.
	initial begin : receiver
		int run_len;
		int stall_len;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? 50 : $urandom_range(1, 12);
			case ($urandom_range(0, 7))
			0, 1:    stall_len = 0;
			2:       stall_len = $urandom_range(12, 24);
			default: stall_len = $urandom_range(1, 5);
			endcase
			repeat (run_len) @(negedge clk) m_tready <= 1'b1;
			repeat (stall_len) @(negedge clk) m_tready <= 1'b0;
		end
	end

	// Compare each result item as it is taken.
	initial begin : result_monitor
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
		end
	end

	// End the run if no item moves on either side for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		logic [COUNT_W-1:0]  limit_plan[6];
		logic [FUNC_W-1:0]   f;
		logic [CLIENT_W-1:0] cid;
		logic                pr;
		logic [SERVER_W-1:0] sid;
		int                  arrive_pct;
		int                  dispatch_pct;
		int                  finish_pct;
		int                  pick;

		sb         = new();
		burst_left = 0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = FUNC_ARRIVE;

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed, limit at its reset value.
		send_item(FUNC_DISPATCH, 6'd0, 1'b0, 3'd7);   // both queues empty
		send_item(FUNC_LEAVE, 6'd63, 1'b1, 3'd0);     // count stays at zero
		send_item(FUNC_FINISH, 6'd5, 1'b0, 3'd0);     // finish with no assignment
		send_item(FUNC_ARRIVE, 6'd0, 1'b0, 3'd0);
		send_item(FUNC_ARRIVE, 6'd42, 1'b1, 3'd5);
		send_item(FUNC_DISPATCH, 6'd0, 1'b0, 3'd7);   // priority head first
		send_item(FUNC_DISPATCH, 6'd63, 1'b1, 3'd0);  // fall back to normal queue
		send_item(FUNC_FINISH, 6'd42, 1'b0, 3'd0);

		// Directed, limit 1 with two admitted already.
		write_max_inside(8'd1);
		send_item(FUNC_DISPATCH, 6'd0, 1'b0, 3'd3);   // empty beats the limit
		send_item(FUNC_ARRIVE, 6'd63, 1'b0, 3'd0);
		send_item(FUNC_DISPATCH, 6'd0, 1'b0, 3'd2);   // limit reached, queue kept
		for (int i = 0; i < QUEUE_DEPTH; i++)         // last one finds the queue full
			send_item(FUNC_ARRIVE, CLIENT_W'(i * 5), 1'b0, SERVER_W'(i));

		// Random phases over several limits, the extremes among them.
		limit_plan[0] = 8'd0;
		limit_plan[1] = 8'd255;
		limit_plan[2] = 8'd1;
		limit_plan[3] = MAX_INSIDE_RESET;
		limit_plan[4] = COUNT_W'($urandom_range(2, 32));
		limit_plan[5] = COUNT_W'($urandom_range(1, 255));

		foreach (limit_plan[p]) begin
			write_max_inside(limit_plan[p]);
			// shift the mix per phase so queues both fill up and run dry
			arrive_pct   = $urandom_range(25, 55);
			dispatch_pct = $urandom_range(20, 35);
			finish_pct   = (100 - arrive_pct - dispatch_pct) / 2;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < arrive_pct) f = FUNC_ARRIVE;
				else if (pick < arrive_pct + dispatch_pct) f = FUNC_DISPATCH;
				else if (pick < arrive_pct + dispatch_pct + finish_pct) f = FUNC_FINISH;
				else f = FUNC_LEAVE;
				cid = CLIENT_W'($urandom_range(0, 63));
				// finish and leave mostly follow a recent grant
				if ((f == FUNC_FINISH || f == FUNC_LEAVE) && sb.recent_grants.size() > 0 &&
						$urandom_range(0, 3) != 0)
					cid = sb.recent_grants[$urandom_range(0, sb.recent_grants.size() - 1)];
				pr  = 1'($urandom_range(0, 1));
				sid = SERVER_W'($urandom_range(0, 7));
				send_item(f, cid, pr, sid);
			end
		end

		// Drop valid, wait out the pending results, then idle before the verdict.
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
rtl/tcpaq_pkg.sv
rtl/tcpaq_queue.sv
rtl/tcpaq_status_store.sv
rtl/two_class_priority_admission_queue.sv
test/two_class_priority_admission_queue_tb.sv
